[design/cshc_pkg.sv]
`timescale 1ns / 1ps

package cshc_pkg;

    // Table geometry. SLOTS must be a power of two so that the probe wraps by truncation.
    localparam int SLOTS      = 4096;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MAX_PROBES = 32;
    localparam int PROBE_W    = $clog2(MAX_PROBES + 1);

    localparam int WORD_W     = 32;
    localparam int OUT_SLOT_W = 12;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 144;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WORD_W-1:0] MIX_MUL_A = 32'h7feb352d;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 32'h846ca68b;
    localparam logic [WORD_W-1:0] SAT32     = 32'hffffffff;

    localparam logic [WORD_W-1:0] RANGE_BASE_RESET = 32'h00400000;
    localparam logic [WORD_W-1:0] RANGE_END_RESET  = 32'h02000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_BASE = 1'b0,
        CFG_RANGE_END  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUT_RANGE = 2'd0,
        OUT_NEW   = 2'd1,
        OUT_HIT   = 2'd2,
        OUT_FULL  = 2'd3
    } outcome_t;

    // One write into the slot stores.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] hits;
        logic [WORD_W-1:0] arg;
    } tbl_wr_t;

    // Read data of the slot stores, registered: valid in the cycle after the address.
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] hits;
    } tbl_rd_t;

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
        return (v == SAT32) ? v : v + WORD_W'(1);
    endfunction

endpackage

[design/call_site_hit_counter_hash_table.sv]
`timescale 1ns / 1ps
// An out-of-range address goes from ST_IDLE to ST_RESULT and then to the output register;
// an in-range address passes the hash pipeline, then probes k = 1..32, then ST_RESULT.
// Only one item is in flight: s_tready stays low from acceptance until the result is loaded; each probe
// is a read of the slot memories followed by a compare and write-back step.
// Reset is synchronous, active low; afterwards a sweep over all 4096 slots clears the key memory
// and s_tready stays low until it ends. Configuration writes are taken at all times.

module call_site_hit_counter_hash_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cshc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cshc_pkg::WORD_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // caller_address [31:0], argument_value [63:32]
    input  logic [cshc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // outcome [1:0], slot_index [13:2], hit_count [45:14], total_count [77:46],
    // in_range_count [109:78], out_of_range_count [141:110], zero [143:142]
    output logic [cshc_pkg::M_TDATA_W-1:0]    m_tdata
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_HASH   = 6'b000100,
        ST_RD     = 6'b001000,
        ST_CHK    = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;

    logic [cshc_pkg::WORD_W-1:0]    range_base_reg, range_end_reg;
    logic [cshc_pkg::WORD_W-1:0]    total_reg, total_next;
    logic [cshc_pkg::WORD_W-1:0]    in_reg, in_next;
    logic [cshc_pkg::WORD_W-1:0]    oor_reg, oor_next;

    logic [cshc_pkg::WORD_W-1:0]    addr_reg, addr_next;
    logic [cshc_pkg::WORD_W-1:0]    arg_reg, arg_next;
    logic [cshc_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [cshc_pkg::PROBE_W-1:0]   probe_reg, probe_next;

    cshc_pkg::outcome_t             res_outcome_reg, res_outcome_next;
    logic [cshc_pkg::SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [cshc_pkg::WORD_W-1:0]    res_hits_reg, res_hits_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [cshc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                           accept, in_range, load_out;
    logic [cshc_pkg::WORD_W-1:0]    s_addr, s_arg;

    logic                           hash_valid;
    logic [cshc_pkg::WORD_W-1:0]    hash_out;

    cshc_pkg::tbl_wr_t              tbl_wr;
    cshc_pkg::tbl_rd_t              tbl_rd;
    logic                           clr_busy;

    cshc_hash u_hash (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .addr_in    (s_addr),
        .hash_valid (hash_valid),
        .hash_out   (hash_out)
    );

    cshc_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (slot_reg),
        .wr       (tbl_wr),
        .rd       (tbl_rd),
        .clr_busy (clr_busy)
    );

    assign s_addr   = s_tdata[cshc_pkg::WORD_W-1:0];
    assign s_arg    = s_tdata[2*cshc_pkg::WORD_W-1:cshc_pkg::WORD_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (s_addr >= range_base_reg) && (s_addr < range_end_reg);
    assign load_out = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next       = state_reg;
        total_next       = total_reg;
        in_next          = in_reg;
        oor_next         = oor_reg;
        addr_next        = addr_reg;
        arg_next         = arg_reg;
        slot_next        = slot_reg;
        probe_next       = probe_reg;
        res_outcome_next = res_outcome_reg;
        res_slot_next    = res_slot_reg;
        res_hits_next    = res_hits_reg;
        tbl_wr           = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                if (!clr_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    total_next = cshc_pkg::sat_inc(total_reg);
                    addr_next  = s_addr;
                    arg_next   = s_arg;
                    probe_next = '0;
                    if (in_range) begin
                        in_next    = cshc_pkg::sat_inc(in_reg);
                        state_next = ST_HASH;
                    end else begin
                        oor_next         = cshc_pkg::sat_inc(oor_reg);
                        res_outcome_next = cshc_pkg::OUT_RANGE;
                        res_slot_next    = '0;
                        res_hits_next    = '0;
                        state_next       = ST_RESULT;
                    end
                end
            end
            ST_HASH: begin
                if (hash_valid) begin
                    slot_next  = hash_out[cshc_pkg::SLOT_W-1:0];
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                // An empty slot wins over a match, so a zero address is never reported as a hit.
                if (tbl_rd.key == '0 || tbl_rd.key == addr_reg) begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = slot_reg;
                    tbl_wr.key  = addr_reg;
                    tbl_wr.arg  = arg_reg;
                    if (tbl_rd.key == '0) begin
                        tbl_wr.hits      = cshc_pkg::WORD_W'(1);
                        res_outcome_next = cshc_pkg::OUT_NEW;
                    end else begin
                        tbl_wr.hits      = cshc_pkg::sat_inc(tbl_rd.hits);
                        res_outcome_next = cshc_pkg::OUT_HIT;
                    end
                    res_slot_next = slot_reg;
                    res_hits_next = tbl_wr.hits;
                    state_next    = ST_RESULT;
                end else if (probe_reg == cshc_pkg::PROBE_W'(cshc_pkg::MAX_PROBES - 1)) begin
                    res_outcome_next = cshc_pkg::OUT_FULL;
                    res_slot_next    = '0;
                    res_hits_next    = '0;
                    state_next       = ST_RESULT;
                end else begin
                    slot_next  = slot_reg + cshc_pkg::SLOT_W'(1);
                    probe_next = probe_reg + cshc_pkg::PROBE_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_RESULT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, oor_reg, in_reg, total_reg, res_hits_reg,
                             cshc_pkg::OUT_SLOT_W'(res_slot_reg), res_outcome_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg        <= addr_next;
        arg_reg         <= arg_next;
        slot_reg        <= slot_next;
        probe_reg       <= probe_next;
        res_outcome_reg <= res_outcome_next;
        res_slot_reg    <= res_slot_next;
        res_hits_reg    <= res_hits_next;
        m_tdata_reg     <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            total_reg    <= '0;
            in_reg       <= '0;
            oor_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            in_reg       <= in_next;
            oor_reg      <= oor_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_base_reg <= cshc_pkg::RANGE_BASE_RESET;
            range_end_reg  <= cshc_pkg::RANGE_END_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cshc_pkg::CFG_RANGE_BASE: range_base_reg <= cfg_wdata;
                cshc_pkg::CFG_RANGE_END:  range_end_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No item may enter while the key memory is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !clr_busy)
        else $error("input accepted during key clearing sweep");

    // Slot memories are written back only in the compare cycle of a probe.
    a_write_in_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> (state_reg == ST_CHK))
        else $error("slot write outside compare cycle");

    // Out-of-range and dropped results carry zero slot and hit count.
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == cshc_pkg::OUT_RANGE ||
                      m_tdata[1:0] == cshc_pkg::OUT_FULL)) |-> (m_tdata[45:2] == '0))
        else $error("nonzero slot or hits on a result without a slot");

    // The probe count never runs past the last allowed probe.
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK) |-> (probe_reg < cshc_pkg::PROBE_W'(cshc_pkg::MAX_PROBES)))
        else $error("probe count beyond limit");

    // An inserted slot always reports a single hit.
    a_new_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && res_outcome_reg == cshc_pkg::OUT_NEW) |=>
            (m_tdata[45:14] == cshc_pkg::WORD_W'(1)))
        else $error("inserted slot with hit count other than one");

endmodule

[design/cshc_hash.sv]
`timescale 1ns / 1ps

module cshc_hash (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cshc_pkg::WORD_W-1:0]  addr_in,
    output logic                         hash_valid,
    output logic [cshc_pkg::WORD_W-1:0]  hash_out
);

    logic                        v1_reg, v2_reg;
    logic [cshc_pkg::WORD_W-1:0] p1_reg, p1_next;
    logic [cshc_pkg::WORD_W-1:0] p2_reg, p2_next;
    logic [cshc_pkg::WORD_W-1:0] x1, x2;

    // Each multiply keeps only its low word, as the mix is defined modulo 2^32.
    always_comb begin
        x1      = addr_in ^ (addr_in >> 16);
        p1_next = cshc_pkg::WORD_W'(x1 * cshc_pkg::MIX_MUL_A);
        x2      = p1_reg ^ (p1_reg >> 15);
        p2_next = cshc_pkg::WORD_W'(x2 * cshc_pkg::MIX_MUL_B);
    end

    always_ff @(posedge aclk) begin
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    assign hash_valid = v2_reg;
    assign hash_out   = p2_reg ^ (p2_reg >> 16);

endmodule

[design/cshc_table.sv]
`timescale 1ns / 1ps

module cshc_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cshc_pkg::SLOT_W-1:0]   rd_addr,
    input  cshc_pkg::tbl_wr_t             wr,
    output cshc_pkg::tbl_rd_t             rd,
    output logic                          clr_busy
);

    logic [cshc_pkg::WORD_W-1:0]   key_mem  [cshc_pkg::SLOTS];
    logic [2*cshc_pkg::WORD_W-1:0] data_mem [cshc_pkg::SLOTS];

    logic [cshc_pkg::WORD_W-1:0]   key_rd_reg;
    logic [2*cshc_pkg::WORD_W-1:0] data_rd_reg;
    logic                          clr_reg;
    logic [cshc_pkg::SLOT_W-1:0]   clr_idx_reg;

    logic                          key_we;
    logic [cshc_pkg::SLOT_W-1:0]   key_waddr;
    logic [cshc_pkg::WORD_W-1:0]   key_wdata;

    // The clearing sweep owns the key port after reset; hits and arguments need no clearing.
    always_comb begin
        key_we    = clr_reg | wr.en;
        key_waddr = clr_reg ? clr_idx_reg : wr.addr;
        key_wdata = clr_reg ? '0 : wr.key;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr.en && !clr_reg) begin
            data_mem[wr.addr] <= {wr.arg, wr.hits};
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end else if (clr_reg) begin
            clr_idx_reg <= clr_idx_reg + cshc_pkg::SLOT_W'(1);
            if (clr_idx_reg == cshc_pkg::SLOT_W'(cshc_pkg::SLOTS - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    assign rd.key   = key_rd_reg;
    assign rd.hits  = data_rd_reg[cshc_pkg::WORD_W-1:0];
    assign clr_busy = clr_reg;

endmodule
